/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/tnon_pkg.sv */
// ----------------------------------------------------------------------------
// tnon_pkg
// types, byte codes and reply tables of the telnet option negotiator
// ----------------------------------------------------------------------------
`default_nettype none

package tnon_pkg;

	localparam int SUB_CAPACITY_DEF = 64;
	localparam int QDEPTH           = 4;

	// request codes
	localparam logic [1:0] REQ_RX     = 2'd0;
	localparam logic [1:0] REQ_TX     = 2'd1;
	localparam logic [1:0] REQ_SIZE   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// telnet command bytes
	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_NUL  = 8'd0;

	// option codes
	localparam logic [7:0] OPTION_ECHO  = 8'd1;
	localparam logic [7:0] OPTION_SGA   = 8'd3;
	localparam logic [7:0] OPTION_TTYPE = 8'd24;
	localparam logic [7:0] OPTION_NAWS  = 8'd31;
	localparam logic [7:0] SUBCMD_SEND  = 8'd1;
	localparam logic [7:0] SUBCMD_IS    = 8'd0;
	localparam logic [7:0] NO_OPTION    = 8'd255;

	localparam logic [7:0] RL_MAGIC = 8'hff;
	localparam logic [7:0] RL_S     = "s";

	localparam logic [7:0] CLIENT_ID [8] = '{"s", "y", "n", "c", "t", "e", "r", "m"};

	localparam logic DEST_APP  = 1'b0;
	localparam logic DEST_LINK = 1'b1;

	localparam logic [15:0] COLS_RST = 16'd80;
	localparam logic [15:0] ROWS_RST = 16'd25;

	typedef enum logic [2:0] {
		PS_DATA,
		PS_IAC,
		PS_WILL,
		PS_WONT,
		PS_DO,
		PS_DONT,
		PS_SB,
		PS_SB_IAC
	} ps_t;

	typedef enum logic [2:0] {
		JK_DATA,
		JK_ESC,
		JK_CMD,
		JK_NAWS,
		JK_RPT_TN,
		JK_RPT_RL,
		JK_TTYPE
	} job_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic [15:0] new_cols;
		logic [15:0] new_rows;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_dest;
		logic       last_of_run;
	} rsp_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  opt;
		logic [7:0]  cmd;
		logic        dest;
		logic [15:0] cols;
		logic [15:0] rows;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [3:0] job_len(job_kind_t kind);
		logic [3:0] n;
		case (kind)
			JK_DATA:   n = 4'd1;
			JK_ESC:    n = 4'd2;
			JK_CMD:    n = 4'd3;
			JK_NAWS:   n = 4'd12;
			JK_RPT_TN: n = 4'd9;
			JK_RPT_RL: n = 4'd12;
			JK_TTYPE:  n = 4'd14;
			default:   n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] tn_report_byte(logic [15:0] cols, logic [15:0] rows,
			logic [3:0] k);
		logic [7:0] b;
		case (k)
			4'd0:    b = B_IAC;
			4'd1:    b = B_SB;
			4'd2:    b = OPTION_NAWS;
			4'd3:    b = cols[15:8];
			4'd4:    b = cols[7:0];
			4'd5:    b = rows[15:8];
			4'd6:    b = rows[7:0];
			4'd7:    b = B_IAC;
			4'd8:    b = B_SE;
			default: b = B_SE;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] job_byte(job_t j, logic [3:0] idx);
		logic [7:0] b;
		logic [3:0] k;
		k = 4'd0;
		case (j.kind)
			JK_DATA: b = j.opt;
			JK_ESC:  b = B_IAC;
			JK_CMD: begin
				case (idx)
					4'd0:    b = B_IAC;
					4'd1:    b = j.cmd;
					default: b = j.opt;
				endcase
			end
			JK_NAWS: begin
				k = idx - 4'd3;
				case (idx)
					4'd0:    b = B_IAC;
					4'd1:    b = B_WILL;
					4'd2:    b = OPTION_NAWS;
					default: b = tn_report_byte(j.cols, j.rows, k);
				endcase
			end
			JK_RPT_TN: b = tn_report_byte(j.cols, j.rows, idx);
			JK_RPT_RL: begin
				case (idx)
					4'd0, 4'd1: b = RL_MAGIC;
					4'd2, 4'd3: b = RL_S;
					4'd4:       b = j.rows[15:8];
					4'd5:       b = j.rows[7:0];
					4'd6:       b = j.cols[15:8];
					4'd7:       b = j.cols[7:0];
					default:    b = B_NUL;
				endcase
			end
			JK_TTYPE: begin
				k = idx - 4'd4;
				case (idx)
					4'd0:    b = B_IAC;
					4'd1:    b = B_SB;
					4'd2:    b = OPTION_TTYPE;
					4'd3:    b = SUBCMD_IS;
					4'd12:   b = B_IAC;
					4'd13:   b = B_SE;
					default: b = CLIENT_ID[k[2:0]];
				endcase
			end
			default: b = B_NUL;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tnon_front.sv */
// ----------------------------------------------------------------------------
// tnon_front
// accepts requests, runs the iac parser and turns requests into jobs where due
// ----------------------------------------------------------------------------
`default_nettype none

module tnon_front #(
	parameter int SUB_CAPACITY = tnon_pkg::SUB_CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire tnon_pkg::req_t req,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	output tnon_pkg::job_t      job,
	output logic                job_push
);

	localparam int CNT_W = $clog2(SUB_CAPACITY + 1);

	tnon_pkg::ps_t ps_q, ps_n;
	logic [7:0]       sub_option_q, sub_option_n;
	logic [7:0]       sub_first_q, sub_first_n;
	logic [CNT_W-1:0] sub_count_q, sub_count_n;
	logic             rlogin_acked_q, rlogin_acked_n;
	logic             naws_on_q, naws_on_n;
	logic [15:0]      cols_q, cols_n;
	logic [15:0]      rows_q, rows_n;
	logic             mode_q;
	logic             has_job;
	logic [7:0]       b;

	assign b        = req.data_byte;
	assign job_push = accept && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q           <= tnon_pkg::PS_DATA;
			sub_option_q   <= tnon_pkg::NO_OPTION;
			sub_first_q    <= '0;
			sub_count_q    <= '0;
			rlogin_acked_q <= 1'b0;
			naws_on_q      <= 1'b0;
			cols_q         <= tnon_pkg::COLS_RST;
			rows_q         <= tnon_pkg::ROWS_RST;
			mode_q         <= 1'b0;
		end else begin
			if (accept) begin
				ps_q           <= ps_n;
				sub_option_q   <= sub_option_n;
				sub_first_q    <= sub_first_n;
				sub_count_q    <= sub_count_n;
				rlogin_acked_q <= rlogin_acked_n;
				naws_on_q      <= naws_on_n;
				cols_q         <= cols_n;
				rows_q         <= rows_n;
			end
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		ps_n           = ps_q;
		sub_option_n   = sub_option_q;
		sub_first_n    = sub_first_q;
		sub_count_n    = sub_count_q;
		rlogin_acked_n = rlogin_acked_q;
		naws_on_n      = naws_on_q;
		cols_n         = cols_q;
		rows_n         = rows_q;
		has_job        = 1'b0;
		job.kind       = tnon_pkg::JK_DATA;
		job.opt        = b;
		job.cmd        = tnon_pkg::B_WONT;
		job.dest       = tnon_pkg::DEST_APP;
		job.cols       = cols_q;
		job.rows       = rows_q;

		case (req.req_type)
			tnon_pkg::REQ_RX: begin
				if (mode_q) begin
					rlogin_acked_n = 1'b1;
					has_job        = rlogin_acked_q || (b != tnon_pkg::B_NUL);
				end else begin
					case (ps_q)
						tnon_pkg::PS_DATA: begin
							if (b == tnon_pkg::B_IAC) begin
								ps_n = tnon_pkg::PS_IAC;
							end else begin
								has_job = 1'b1;
							end
						end
						tnon_pkg::PS_IAC: begin
							ps_n = tnon_pkg::PS_DATA;
							if (b == tnon_pkg::B_IAC) begin
								has_job = 1'b1;
							end else if (b == tnon_pkg::B_WILL) begin
								ps_n = tnon_pkg::PS_WILL;
							end else if (b == tnon_pkg::B_WONT) begin
								ps_n = tnon_pkg::PS_WONT;
							end else if (b == tnon_pkg::B_DO) begin
								ps_n = tnon_pkg::PS_DO;
							end else if (b == tnon_pkg::B_DONT) begin
								ps_n = tnon_pkg::PS_DONT;
							end else if (b == tnon_pkg::B_SB) begin
								ps_n         = tnon_pkg::PS_SB;
								sub_option_n = tnon_pkg::NO_OPTION;
								sub_count_n  = '0;
							end
						end
						tnon_pkg::PS_WILL: begin
							ps_n     = tnon_pkg::PS_DATA;
							has_job  = 1'b1;
							job.kind = tnon_pkg::JK_CMD;
							job.dest = tnon_pkg::DEST_LINK;
							job.cmd  = (b == tnon_pkg::OPTION_ECHO ||
								b == tnon_pkg::OPTION_SGA) ?
								tnon_pkg::B_DO : tnon_pkg::B_DONT;
						end
						tnon_pkg::PS_DO: begin
							ps_n     = tnon_pkg::PS_DATA;
							has_job  = 1'b1;
							job.kind = tnon_pkg::JK_CMD;
							job.dest = tnon_pkg::DEST_LINK;
							if (b == tnon_pkg::OPTION_NAWS) begin
								naws_on_n = 1'b1;
								job.kind  = tnon_pkg::JK_NAWS;
							end else if (b == tnon_pkg::OPTION_SGA ||
									b == tnon_pkg::OPTION_TTYPE) begin
								job.cmd = tnon_pkg::B_WILL;
							end else begin
								job.cmd = tnon_pkg::B_WONT;
							end
						end
						tnon_pkg::PS_SB: begin
							if (b == tnon_pkg::B_IAC) begin
								ps_n = tnon_pkg::PS_SB_IAC;
							end else if (sub_option_q == tnon_pkg::NO_OPTION) begin
								sub_option_n = b;
							end else if (sub_count_q < CNT_W'(SUB_CAPACITY)) begin
								if (sub_count_q == '0) begin
									sub_first_n = b;
								end
								sub_count_n = sub_count_q + 1'b1;
							end
						end
						tnon_pkg::PS_SB_IAC: begin
							ps_n = tnon_pkg::PS_DATA;
							if (b == tnon_pkg::B_SE) begin
								if (sub_option_q == tnon_pkg::OPTION_TTYPE &&
										sub_count_q != '0 &&
										sub_first_q == tnon_pkg::SUBCMD_SEND) begin
									has_job  = 1'b1;
									job.kind = tnon_pkg::JK_TTYPE;
									job.dest = tnon_pkg::DEST_LINK;
								end
							end else if (b == tnon_pkg::B_IAC) begin
								ps_n = tnon_pkg::PS_SB;
								if (sub_count_q < CNT_W'(SUB_CAPACITY)) begin
									if (sub_count_q == '0) begin
										sub_first_n = b;
									end
									sub_count_n = sub_count_q + 1'b1;
								end
							end
						end
						default: begin
							ps_n = tnon_pkg::PS_DATA;
						end
					endcase
				end
			end
			tnon_pkg::REQ_TX: begin
				has_job  = 1'b1;
				job.dest = tnon_pkg::DEST_LINK;
				if (!mode_q && b == tnon_pkg::B_IAC) begin
					job.kind = tnon_pkg::JK_ESC;
				end
			end
			tnon_pkg::REQ_SIZE: begin
				cols_n   = req.new_cols;
				rows_n   = req.new_rows;
				job.cols = req.new_cols;
				job.rows = req.new_rows;
				job.dest = tnon_pkg::DEST_LINK;
				has_job  = naws_on_q || mode_q;
				job.kind = mode_q ? tnon_pkg::JK_RPT_RL : tnon_pkg::JK_RPT_TN;
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/tnon_jobq.sv */
// ----------------------------------------------------------------------------
// tnon_jobq
// short job queue between the parser front and the byte emitter
// ----------------------------------------------------------------------------
`default_nettype none

module tnon_jobq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire tnon_pkg::job_t wr_job,
	input  wire logic           rd,
	output tnon_pkg::job_t      head,
	output tnon_pkg::q_stat_t   stat
);

	localparam int PW = $clog2(tnon_pkg::QDEPTH);
	localparam int CW = $clog2(tnon_pkg::QDEPTH + 1);

	tnon_pkg::job_t entry_q [tnon_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign stat.full  = (count_q == CW'(tnon_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tnon_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tnon_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tnon_back.sv */
// ----------------------------------------------------------------------------
// tnon_back
// expands queued jobs into result bytes in the output reg, one per cycle if free
// ----------------------------------------------------------------------------
`default_nettype none

module tnon_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tnon_pkg::job_t    head,
	input  wire tnon_pkg::q_stat_t q_stat,
	output logic                   q_rd,
	input  wire logic              pop,
	output logic                   empty,
	output tnon_pkg::rsp_t         rsp
);

	logic [3:0]     idx_q;
	logic           out_valid_q;
	tnon_pkg::rsp_t rsp_q;
	logic           advance;
	logic           take;
	logic           last;

	assign advance = !out_valid_q || pop;
	assign take    = advance && !q_stat.empty;
	assign last    = (idx_q == 4'(tnon_pkg::job_len(head.kind) - 4'd1));
	assign q_rd    = take && last;
	assign empty   = !out_valid_q;
	assign rsp     = rsp_q;

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.out_byte    <= tnon_pkg::job_byte(head, idx_q);
			rsp_q.out_dest    <= head.dest;
			rsp_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q       <= last ? 4'd0 : idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/telnet_option_negotiator.sv */
// ----------------------------------------------------------------------------
// telnet_option_negotiator
// telnet client iac deframer, option replies and window size reports
//
//   channel   signals                    transaction when
//   request   push, full, req            push && !full
//   result    empty, pop, rsp            pop && !empty
//   config    cfg_we, cfg_wdata          cfg_we
//
// one request per cycle is accepted while the job queue has room
// the emitter sends one result byte per cycle while the output register is
// free or popped; a request with n results holds the emitter until all n
// are sent (up to 14 for the terminal type reply); the first result passes
// through the job queue and then the output register; no clearing pass after
// reset; full and empty depend only on queue and output register occupancy
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_option_negotiator #(
	parameter int SUB_CAPACITY = tnon_pkg::SUB_CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire tnon_pkg::req_t req,
	output logic                empty,
	input  wire logic           pop,
	output tnon_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);

	tnon_pkg::job_t    job;
	tnon_pkg::job_t    head;
	tnon_pkg::q_stat_t q_stat;
	logic              job_push;
	logic              q_rd;
	logic              accept;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	tnon_front #(
		.SUB_CAPACITY(SUB_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.job      (job),
		.job_push (job_push)
	);

	tnon_jobq u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (job_push),
		.wr_job(job),
		.rd    (q_rd),
		.head  (head),
		.stat  (q_stat)
	);

	tnon_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.q_stat(q_stat),
		.q_rd  (q_rd),
		.pop   (pop),
		.empty (empty),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

/* rtl/core/tnon_checker.sv */
// ----------------------------------------------------------------------------
// tnon_checker
// port-level checks on the negotiator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tnon_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           push,
	input wire logic           full,
	input wire logic           empty,
	input wire logic           pop,
	input wire tnon_pkg::rsp_t rsp
);

	// a waiting result holds until taken
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, !empty && !pop, !empty && $stable(rsp))

	// the queue only fills after a pushed request
	`ASSERT_IMPLIES(a_full_after_push, clk, arst_n, $rose(full), $past(push))

	// a run continues without a gap once its first byte is taken
	`ASSERT_NEXT(a_run_no_gap, clk, arst_n, !empty && pop && !rsp.last_of_run, !empty)

endmodule

bind telnet_option_negotiator tnon_checker u_tnon_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.rsp   (rsp)
);

`default_nettype wire
